// ===== rtl/core/tccs_pkg.sv =====
// types, constants and field layout shared by the text console blocks
`timescale 1ns / 1ps
package tccs_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CELL_W = 16;

  localparam int F_OP_W     = 2;
  localparam int F_CHAR_W   = 8;
  localparam int F_COLUMN_W = 7;
  localparam int F_ROW_W    = 5;
  localparam int F_CELL_W   = 16;
  localparam int F_CCOL_W   = 7;
  localparam int F_CLINE_W  = 5;
  localparam int COLOR_W    = 8;

  localparam int IN_FIELDS_W  = F_OP_W + F_CHAR_W + F_COLUMN_W + F_ROW_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = F_CELL_W + F_CCOL_W + F_CLINE_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [F_CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [CELL_W-1:0]   BLANK_CELL   = 16'h0720;
  localparam logic [COLOR_W-1:0]  COLOR_RESET  = 8'h07;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_SETPOS = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } tccs_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCRUB
  } tccs_state_e;

  typedef struct packed {
    logic accept;
    logic sweep_we;
    logic load_read;
  } tccs_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_scroll;
    logic sweep_done;
    logic out_free;
  } tccs_sts_t;

endpackage

// ===== rtl/core/tccs_ctrl.sv =====
// controller state machine for the text console
`timescale 1ns / 1ps
module tccs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tccs_pkg::tccs_sts_t sts_i,
  output tccs_pkg::tccs_cmd_t cmd_o
);
  import tccs_pkg::*;

  tccs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.sweep_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && sts_i.out_free) begin
          if (sts_i.is_read) begin
            state_d = ST_READ;
          end else if (sts_i.is_scroll) begin
            state_d = ST_SCRUB;
          end
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SCRUB: begin
        if (sts_i.sweep_done) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.sweep_we  = 1'b0;
    cmd_o.load_read = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = sts_i.out_free;
        cmd_o.accept = sts_i.out_free && in_valid_i;
      end
      ST_READ: begin
        cmd_o.load_read = 1'b1;
      end
      ST_SCRUB: begin
        cmd_o.sweep_we = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/tccs_dpath.sv =====
// datapath for the text console: screen memory, cursor, scroll offset, output register
`timescale 1ns / 1ps
module tccs_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tccs_pkg::tccs_cmd_t                  cmd_i,
  output tccs_pkg::tccs_sts_t                  sts_o,
  input  logic                                 cfg_we_i,
  input  logic [tccs_pkg::COLOR_W-1:0]         cfg_wdata_i,
  input  logic [tccs_pkg::IN_DATA_W-1:0]       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [tccs_pkg::OUT_DATA_W-1:0]      out_data_o
);
  import tccs_pkg::*;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r,
                                                  logic [ROW_W-1:0] top,
                                                  logic [COL_W-1:0] c);
    logic [ROW_W:0]   s;
    logic [ROW_W-1:0] p;
    s = {1'b0, r} + {1'b0, top};
    if (s >= (ROW_W+1)'(SCREEN_ROWS)) s = s - (ROW_W+1)'(SCREEN_ROWS);
    p = s[ROW_W-1:0];
    return ADDR_W'(p) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(c);
  endfunction

  tccs_op_e              op;
  logic [F_CHAR_W-1:0]   char_code;
  logic [F_COLUMN_W-1:0] col_in;
  logic [F_ROW_W-1:0]    row_in;
  logic [COL_W-1:0]      col_c;
  logic [ROW_W-1:0]      row_c;

  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [ROW_W-1:0]      top_q, top_d;
  logic [COL_W:0]        col_inc;
  logic [ROW_W:0]        row_inc;
  logic                  next_row;
  logic                  scroll;
  logic [COLOR_W-1:0]    color_q;

  logic [CELL_W-1:0]     mem [CELL_COUNT];
  logic [CELL_W-1:0]     rd_q;
  logic                  mem_we;
  logic [ADDR_W-1:0]     waddr;
  logic [CELL_W-1:0]     wdata;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     sweep_addr_q;
  logic [ADDR_W-1:0]     sweep_last_q;
  logic [ADDR_W-1:0]     sweep_base;
  logic                  sweep_done;

  logic                  out_valid_q;
  logic [F_CELL_W-1:0]   out_cell_q;
  logic [F_CCOL_W-1:0]   out_col_q;
  logic [F_CLINE_W-1:0]  out_line_q;
  logic                  out_scroll_q;

  assign op        = tccs_op_e'(in_data_i[F_OP_W-1:0]);
  assign char_code = in_data_i[F_OP_W +: F_CHAR_W];
  assign col_in    = in_data_i[F_OP_W + F_CHAR_W +: F_COLUMN_W];
  assign row_in    = in_data_i[F_OP_W + F_CHAR_W + F_COLUMN_W +: F_ROW_W];

  // saturate positions to the screen
  always_comb begin
    if (int'(col_in) >= SCREEN_COLUMNS) col_c = COL_W'(SCREEN_COLUMNS - 1);
    else                                col_c = COL_W'(col_in);
    if (int'(row_in) >= SCREEN_ROWS) row_c = ROW_W'(SCREEN_ROWS - 1);
    else                             row_c = ROW_W'(row_in);
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    top_d    = top_q;
    scroll   = 1'b0;
    next_row = 1'b0;
    col_inc  = {1'b0, col_q} + (COL_W+1)'(1);
    row_inc  = {1'b0, row_q} + (ROW_W+1)'(1);
    case (op)
      OP_PUT: begin
        if (char_code == NEWLINE_CODE) begin
          next_row = 1'b1;
        end else if (col_inc >= (COL_W+1)'(SCREEN_COLUMNS)) begin
          next_row = 1'b1;
        end else begin
          col_d = col_inc[COL_W-1:0];
        end
        if (next_row) begin
          col_d = '0;
          if (row_inc >= (ROW_W+1)'(SCREEN_ROWS)) begin
            scroll = 1'b1;
            row_d  = ROW_W'(SCREEN_ROWS - 1);
            if (top_q == ROW_W'(SCREEN_ROWS - 1)) top_d = '0;
            else                                  top_d = top_q + ROW_W'(1);
          end else begin
            row_d = row_inc[ROW_W-1:0];
          end
        end
      end
      OP_SETPOS: begin
        col_d = col_c;
        row_d = row_c;
      end
      default: begin
        col_d = col_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      top_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_d;
      row_q <= row_d;
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  // blanking sweep: whole screen after reset, the recycled row after a scroll
  assign sweep_base = cell_addr('0, top_q, '0);
  assign sweep_done = (sweep_addr_q == sweep_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
      sweep_last_q <= ADDR_W'(CELL_COUNT - 1);
    end else if (cmd_i.accept && scroll) begin
      sweep_addr_q <= sweep_base;
      sweep_last_q <= sweep_base + ADDR_W'(SCREEN_COLUMNS - 1);
    end else if (cmd_i.sweep_we && !sweep_done) begin
      sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = cell_addr(row_q, top_q, col_q);
    wdata  = {color_q, char_code};
    if (cmd_i.sweep_we) begin
      mem_we = 1'b1;
      waddr  = sweep_addr_q;
      wdata  = BLANK_CELL;
    end else if (cmd_i.accept && op == OP_PUT && char_code != NEWLINE_CODE) begin
      mem_we = 1'b1;
    end
  end

  assign raddr = cell_addr(row_c, top_q, col_c);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd_i.accept) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_read || (cmd_i.accept && op != OP_READ)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_read) begin
      out_cell_q   <= rd_q;
      out_col_q    <= F_CCOL_W'(col_q);
      out_line_q   <= F_CLINE_W'(row_q);
      out_scroll_q <= 1'b0;
    end else if (cmd_i.accept && op != OP_READ) begin
      out_cell_q   <= '0;
      out_col_q    <= F_CCOL_W'(col_d);
      out_line_q   <= F_CLINE_W'(row_d);
      out_scroll_q <= scroll;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_DATA_W'({out_scroll_q, out_line_q, out_col_q, out_cell_q});

  assign sts_o.is_read    = (op == OP_READ);
  assign sts_o.is_scroll  = scroll;
  assign sts_o.sweep_done = sweep_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < SCREEN_ROWS && int'(top_q) < SCREEN_ROWS)
    else $error("cursor row or top row offset out of range");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.accept && (cmd_i.sweep_we || cmd_i.load_read)))
    else $error("transaction accepted during sweep or read completion");

  a_scroll_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && scroll) |=> (sweep_last_q == sweep_addr_q + ADDR_W'(SCREEN_COLUMNS - 1)))
    else $error("row blanking sweep not set up after scroll");

  a_read_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_read |=> out_valid_q)
    else $error("read result not loaded");

endmodule

// ===== rtl/core/text_console_cursor_scroll.sv =====
// top level of the text console: 80x25 cell screen with cursor and scrolling
`timescale 1ns / 1ps
// After reset the block blanks all 2000 cells through the memory write port, one cell per
// cycle, and takes no transaction until the sweep is done (text_color writes are taken as
// ever). A put, set-position or unused op is accepted in the idle state and its result is
// held in the output register. A read goes through a read state, as the screen memory has a
// registered read port. A put that scrolls gives its result like any put, since scrolling
// only advances a circular top-row offset, but the recycled row is then blanked through the
// single write port before the next transaction is accepted. A new transaction is taken
// while the previous result is being taken on the master side.
module text_console_cursor_scroll (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tccs_pkg::COLOR_W-1:0]       cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // op, char_code, column, row
  input  logic [tccs_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // cell_value, cursor_col, cursor_line, did_scroll
  output logic [tccs_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import tccs_pkg::*;

  tccs_cmd_t cmd;
  tccs_sts_t sts;

  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccs_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== tb/sv/text_console_cursor_scroll_tb.sv =====
// self-checking testbench for the text console: shadow screen, cursor and colour checked per result
`timescale 1ns / 1ps
module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam int STALL_LIMIT = 10000;
  localparam int PHASE_ITEMS = 270;

  typedef struct {
    logic [F_CELL_W-1:0]  cell_value;
    logic [F_CCOL_W-1:0]  col;
    logic [F_CLINE_W-1:0] line;
    logic                 scrolled;
  } console_status_t;

  class console_shadow;
    logic [CELL_W-1:0]  screen [CELL_COUNT];
    int unsigned        cur_col;
    int unsigned        cur_line;
    logic [COLOR_W-1:0] text_color;
    console_status_t    expected_status_q[$];
    int                 mismatches;
    int                 put_count;
    int                 newline_count;
    int                 move_count;
    int                 read_count;
    int                 unused_count;
    int                 scroll_count;

    function new();
      foreach (screen[i]) screen[i] = BLANK_CELL;
      cur_col       = 0;
      cur_line      = 0;
      text_color    = COLOR_RESET;
      mismatches    = 0;
      put_count     = 0;
      newline_count = 0;
      move_count    = 0;
      read_count    = 0;
      unused_count  = 0;
      scroll_count  = 0;
    endfunction

    function int unsigned saturate(int unsigned v, int unsigned limit);
      return (v >= limit) ? limit - 1 : v;
    endfunction

    // start of next row, scrolling the screen up when past the bottom
    function bit advance_line();
      cur_col = 0;
      cur_line++;
      if (cur_line >= SCREEN_ROWS) begin
        for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++) screen[i] = screen[i + SCREEN_COLUMNS];
        for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
        cur_line = SCREEN_ROWS - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_command(tccs_op_e op, logic [F_CHAR_W-1:0] ch,
                               logic [F_COLUMN_W-1:0] col, logic [F_ROW_W-1:0] row);
      console_status_t st;
      st.cell_value = '0;
      st.scrolled   = 1'b0;
      case (op)
        OP_PUT: begin
          put_count++;
          if (ch == NEWLINE_CODE) begin
            newline_count++;
            st.scrolled = advance_line();
          end else begin
            screen[cur_line * SCREEN_COLUMNS + cur_col] = {text_color, ch};
            cur_col++;
            if (cur_col >= SCREEN_COLUMNS) st.scrolled = advance_line();
          end
        end
        OP_SETPOS: begin
          move_count++;
          cur_col  = saturate(col, SCREEN_COLUMNS);
          cur_line = saturate(row, SCREEN_ROWS);
        end
        OP_READ: begin
          read_count++;
          st.cell_value = screen[saturate(row, SCREEN_ROWS) * SCREEN_COLUMNS
                                 + saturate(col, SCREEN_COLUMNS)];
        end
        default: begin
          unused_count++;
        end
      endcase
      if (st.scrolled) scroll_count++;
      st.col  = cur_col[F_CCOL_W-1:0];
      st.line = cur_line[F_CLINE_W-1:0];
      expected_status_q.push_back(st);
    endfunction

    function void check_status(logic [OUT_DATA_W-1:0] data);
      console_status_t exp_st;
      if (expected_status_q.size() == 0) begin
        $error("result %h arrived with no command outstanding", data);
        mismatches++;
        return;
      end
      exp_st = expected_status_q.pop_front();
      if (data[F_CELL_W-1:0] !== exp_st.cell_value) begin
        $error("cell_value expected %h actual %h", exp_st.cell_value, data[F_CELL_W-1:0]);
        mismatches++;
      end
      if (data[F_CELL_W +: F_CCOL_W] !== exp_st.col) begin
        $error("cursor_col expected %0d actual %0d", exp_st.col, data[F_CELL_W +: F_CCOL_W]);
        mismatches++;
      end
      if (data[F_CELL_W + F_CCOL_W +: F_CLINE_W] !== exp_st.line) begin
        $error("cursor_line expected %0d actual %0d", exp_st.line,
               data[F_CELL_W + F_CCOL_W +: F_CLINE_W]);
        mismatches++;
      end
      if (data[F_CELL_W + F_CCOL_W + F_CLINE_W] !== exp_st.scrolled) begin
        $error("did_scroll expected %0b actual %0b", exp_st.scrolled,
               data[F_CELL_W + F_CCOL_W + F_CLINE_W]);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [COLOR_W-1:0]    cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  console_shadow shadow = new();
  bit            steady = 1'b0;
  int            quiet_cycles = 0;
  int            colour_settings = 1;

  text_console_cursor_scroll dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_command(tccs_op_e op, logic [F_CHAR_W-1:0] ch,
                              logic [F_COLUMN_W-1:0] col, logic [F_ROW_W-1:0] row);
    int unsigned          gap;
    logic [IN_DATA_W-1:0] word;
    gap  = steady ? 0 : $urandom_range(0, 8);
    word = '0;
    word[IN_FIELDS_W-1:0] = {row, col, ch, op};
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    shadow.note_command(op, ch, col, row);
  endtask

  task automatic send_random_command();
    int unsigned           pick;
    int unsigned           sel;
    tccs_op_e              op;
    logic [F_CHAR_W-1:0]   ch;
    logic [F_COLUMN_W-1:0] col;
    logic [F_ROW_W-1:0]    row;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    ch   = F_CHAR_W'($urandom_range(0, 255));
    col  = F_COLUMN_W'($urandom_range(0, 127));
    row  = F_ROW_W'($urandom_range(0, 31));
    if (pick < 60) begin
      op = OP_PUT;
      if ($urandom_range(0, 7) == 0) ch = NEWLINE_CODE;
    end else if (pick < 95) begin
      op = (pick < 72) ? OP_SETPOS : OP_READ;
      // mostly on screen, some near the right edge of the bottom or cursor row
      if (sel >= 4) begin
        col = F_COLUMN_W'($urandom_range(0, SCREEN_COLUMNS - 1));
        row = F_ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
      end else if (sel >= 1) begin
        col = F_COLUMN_W'($urandom_range(SCREEN_COLUMNS - 20, SCREEN_COLUMNS - 1));
        row = (op == OP_READ) ? F_ROW_W'(shadow.cur_line) : F_ROW_W'(SCREEN_ROWS - 1);
      end
    end else begin
      op = OP_NONE;
    end
    send_command(op, ch, col, row);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_text_color(logic [COLOR_W-1:0] colour);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= colour;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow.text_color = colour;
    colour_settings++;
  endtask

  initial begin
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      shadow.check_status(m_axis_tdata_o);
    end
  end

  initial begin
    logic [COLOR_W-1:0] phase_colours [5];
    phase_colours[0] = 8'h00;
    phase_colours[1] = 8'hff;
    phase_colours[2] = 8'h5a;
    phase_colours[3] = COLOR_W'($urandom_range(0, 255));
    phase_colours[4] = 8'ha5;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, wrap, scroll, saturation, unused op
    send_command(OP_PUT, 8'h41, 7'd0, 5'd0);
    send_command(OP_PUT, 8'h00, 7'd127, 5'd31);
    send_command(OP_PUT, 8'hff, 7'd0, 5'd0);
    send_command(OP_READ, 8'h00, 7'd0, 5'd0);
    send_command(OP_READ, 8'hff, 7'd127, 5'd31);
    send_command(OP_NONE, 8'h55, 7'h2a, 5'h0a);
    send_command(OP_SETPOS, 8'h00, 7'd127, 5'd31);
    send_command(OP_PUT, 8'h5a, 7'd0, 5'd0);
    send_command(OP_READ, 8'h00, 7'd79, 5'd23);
    send_command(OP_READ, 8'h00, 7'd0, 5'd24);
    send_command(OP_PUT, NEWLINE_CODE, 7'h55, 5'h15);
    send_command(OP_SETPOS, 8'h00, 7'd0, 5'd0);
    send_command(OP_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    send_command(OP_SETPOS, 8'h00, 7'd79, 5'd0);
    send_command(OP_PUT, 8'h2a, 7'd0, 5'd0);
    send_command(OP_SETPOS, 8'h00, 7'd78, 5'd24);
    send_command(OP_PUT, 8'h80, 7'd0, 5'd0);
    send_command(OP_PUT, 8'h7f, 7'd0, 5'd0);
    send_command(OP_READ, 8'h00, 7'd78, 5'd23);
    send_command(OP_READ, 8'h00, 7'h55, 5'h15);
    send_command(OP_READ, 8'h00, 7'h2a, 5'h0a);
    send_command(OP_SETPOS, 8'h00, 7'h40, 5'h10);
    send_command(OP_NONE, 8'hff, 7'd127, 5'd31);
    send_command(OP_SETPOS, 8'h00, 7'd80, 5'd25);

    for (int phase = 0; phase < 5; phase++) begin
      set_text_color(phase_colours[phase]);
      steady = (phase == 2);
      repeat (PHASE_ITEMS) send_random_command();
    end
    steady = 1'b0;

    wait_for_results();
    repeat (SCREEN_COLUMNS + 20) @(posedge clk_i);
    $display("%0d puts (%0d newlines), %0d cursor moves, %0d reads, %0d unused ops",
             shadow.put_count, shadow.newline_count, shadow.move_count,
             shadow.read_count, shadow.unused_count);
    $display("%0d scrolls across %0d text colours, %0d mismatches",
             shadow.scroll_count, colour_settings, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
